// File: rtl/core/sha256_pkg.sv
// shared types, constants and rotate function of the sha-256 hasher
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = 2;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic  msg_end;
    word_t data;
  } qentry_t;

  localparam word_t PadWord = 32'h8000_0000;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/core/sha256_front.sv
// front end: accepts message words, applies padding and length, feeds the queue
module sha256_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha256_pkg::word_t   in_word,
  input  logic [2:0]          in_count,
  input  logic                in_last,
  output logic                q_push,
  output sha256_pkg::qentry_t q_data,
  input  logic                q_full
);

  typedef enum logic [3:0] {
    F_ACCEPT = 4'b0001,
    F_PAD    = 4'b0010,
    F_ZERO   = 4'b0100,
    F_LENLO  = 4'b1000
  } fstate_t;

  fstate_t      state, state_next;
  logic [3:0]   pos;
  logic [63:0]  bit_len;
  logic [2:0]   cnt_sat;
  logic         acc;
  sha256_pkg::word_t keep, pad;

  assign in_ready = (state == F_ACCEPT) && !q_full;
  assign acc      = in_valid && in_ready;
  assign cnt_sat  = (!in_last || in_count > 3'd4) ? 3'd4 : in_count;

  always_comb begin
    case (cnt_sat)
      3'd1:    begin keep = 32'hff00_0000; pad = 32'h0080_0000; end
      3'd2:    begin keep = 32'hffff_0000; pad = 32'h0000_8000; end
      3'd3:    begin keep = 32'hffff_ff00; pad = 32'h0000_0080; end
      default: begin keep = 32'h0000_0000; pad = sha256_pkg::PadWord; end
    endcase
  end

  always_comb begin
    state_next     = state;
    q_push         = 1'b0;
    q_data.msg_end = 1'b0;
    q_data.data    = in_word;
    unique case (state)
      F_ACCEPT: begin
        q_push = acc;
        if (acc && in_last) begin
          if (cnt_sat == 3'd4) begin
            state_next = F_PAD;
          end else begin
            q_data.data = (in_word & keep) | pad;
            state_next  = F_ZERO;
          end
        end
      end
      F_PAD: begin
        q_push      = !q_full;
        q_data.data = sha256_pkg::PadWord;
        if (!q_full) state_next = F_ZERO;
      end
      F_ZERO: begin
        q_push = !q_full;
        if (pos == 4'd14) begin
          q_data.data = bit_len[63:32];
          if (!q_full) state_next = F_LENLO;
        end else begin
          q_data.data = '0;
        end
      end
      F_LENLO: begin
        q_push         = !q_full;
        q_data.data    = bit_len[31:0];
        q_data.msg_end = 1'b1;
        if (!q_full) state_next = F_ACCEPT;
      end
      default: state_next = F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_ACCEPT;
      pos     <= '0;
      bit_len <= '0;
    end else begin
      state <= state_next;
      if (q_push) pos <= q_data.msg_end ? 4'd0 : pos + 4'd1;
      if (q_push && q_data.msg_end) begin
        bit_len <= '0;
      end else if (acc) begin
        bit_len <= bit_len + {58'd0, cnt_sat, 3'd0};
      end
    end
  end

endmodule

// File: rtl/core/sha256_queue.sv
// short word queue between front and back end
module sha256_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sha256_pkg::qentry_t push_data,
  output logic                full,
  input  logic                pop,
  output sha256_pkg::qentry_t pop_data,
  output logic                empty
);

  sha256_pkg::qentry_t mem [sha256_pkg::QueueDepth];
  logic [sha256_pkg::QueueAw-1:0] wptr, rptr;
  logic [sha256_pkg::QueueAw:0]   fill;

  assign full     = fill == (sha256_pkg::QueueAw+1)'(sha256_pkg::QueueDepth);
  assign empty    = fill == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + {{sha256_pkg::QueueAw{1'b0}}, push} - {{sha256_pkg::QueueAw{1'b0}}, pop};
    end
  end

endmodule

// File: rtl/core/sha256_back.sv
// back end: schedule window, 64-round compression and digest register
module sha256_back (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::qentry_t q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [255:0]        out_data
);

  typedef enum logic [2:0] {
    B_LOAD  = 3'b001,
    B_ROUND = 3'b010,
    B_FINAL = 3'b100
  } bstate_t;

  bstate_t state;
  sha256_pkg::word_t win [16];
  sha256_pkg::word_t cv [8];
  sha256_pkg::word_t wv [8];
  logic [3:0] load_cnt;
  logic [5:0] rnd;
  logic       blk_end;
  logic       out_free;
  sha256_pkg::word_t s0, s1, wnew, t1, t2, e, a;
  sha256_pkg::word_t sum [8];

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == B_LOAD) && !q_empty;

  always_comb begin
    s1   = sha256_pkg::rotr(win[14], 17) ^ sha256_pkg::rotr(win[14], 19) ^ (win[14] >> 10);
    s0   = sha256_pkg::rotr(win[1], 7) ^ sha256_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
    wnew = s1 + win[9] + s0 + win[0];
    e    = wv[4];
    a    = wv[0];
    t1   = wv[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
         + ((e & wv[5]) ^ (~e & wv[6])) + sha256_pkg::K[rnd] + win[0];
    t2   = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
         + ((a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]));
    for (int i = 0; i < 8; i++) sum[i] = cv[i] + wv[i];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= q_data.data;
      blk_end <= q_data.msg_end;
    end else if (state == B_ROUND) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= wnew;
    end
    if (state == B_LOAD) begin
      for (int i = 0; i < 8; i++) wv[i] <= cv[i];
    end else if (state == B_ROUND) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
    if (state == B_FINAL && blk_end && out_free) begin
      for (int i = 0; i < 4; i++) begin
        out_data[64*i +: 64] <= {sum[2*i], sum[2*i+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_LOAD;
      load_cnt  <= '0;
      rnd       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) cv[i] <= sha256_pkg::IV[i];
    end else begin
      if (state == B_FINAL && blk_end && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_LOAD: begin
          if (q_pop) begin
            load_cnt <= load_cnt + 4'd1;
            if (load_cnt == 4'd15) state <= B_ROUND;
          end
        end
        B_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= B_FINAL;
        end
        B_FINAL: begin
          if (!blk_end) begin
            for (int i = 0; i < 8; i++) cv[i] <= sum[i];
            state <= B_LOAD;
          end else if (out_free) begin
            for (int i = 0; i < 8; i++) cv[i] <= sha256_pkg::IV[i];
            state <= B_LOAD;
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

endmodule

// File: rtl/core/sha256_message_hasher.sv
// top level of the sha-256 message hasher
// Takes a message as big-endian 32-bit words and returns the 256-bit SHA-256
// digest after the word marked tlast. The front end pads and appends the bit
// length while the back end compresses; a 16-word block is loaded word by
// word in B_LOAD, compressed in 64 rounds in B_ROUND (one round per cycle) and
// finished in B_FINAL, which waits for the output on a message's last block.
// The last word's block is filled out with the pad and length words, and one
// more block follows when the pad leaves no room for the two length words.
module sha256_message_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // message_word [31:0], byte_count [34:32]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata    // digest_high, digest_upper_mid, digest_lower_mid, digest_low
);

  sha256_pkg::qentry_t push_data, pop_data;
  logic push, pop, full, empty;

  sha256_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_word  (s_tdata[31:0]),
    .in_count (s_tdata[34:32]),
    .in_last  (s_tlast),
    .q_push   (push),
    .q_data   (push_data),
    .q_full   (full)
  );

  sha256_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  sha256_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (pop_data),
    .q_empty   (empty),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// File: tb/sha256_digest_checker.sv
`timescale 1ns / 100ps
// checker that predicts sha-256 digests from accepted words and compares them
module sha256_digest_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [255:0] m_tdata,
  output int           fail_count,
  output int           pending_digests
);

  sha256_pkg::word_t blk [16];
  sha256_pkg::word_t chain [8];
  int unsigned fill;
  logic [63:0] msg_bits;
  logic [255:0] digest_q[$];

  assign pending_digests = digest_q.size();

  task automatic compress();
    sha256_pkg::word_t w [16];
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t w2, w15, t1, t2, e, a, s0, s1;
    int r;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (r = 0; r < 64; r++) begin
      if (r >= 16) begin
        w2  = w[(r - 2) & 15];
        w15 = w[(r - 15) & 15];
        s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        w[r & 15] = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
      end
      e = v[4];
      a = v[0];
      t1 = v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & v[5]) ^ (~e & v[6])) + sha256_pkg::K[r] + w[r & 15];
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic load_word(input sha256_pkg::word_t w);
    blk[fill] = w;
    fill = (fill + 1) & 15;
    if (fill == 0) compress();
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::IV[i];
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic absorb_word(input sha256_pkg::word_t w, input logic [2:0] cnt,
                             input logic fin);
    int unsigned n;
    sha256_pkg::word_t keep;
    n = (!fin || cnt > 4) ? 4 : cnt;
    msg_bits += 64'(8 * n);
    if (!fin) begin
      load_word(w);
      return;
    end
    if (n == 4) begin
      load_word(w);
      load_word(sha256_pkg::PadWord);
    end else begin
      keep = (n == 0) ? '0 : (32'hffff_ffff << (32 - 8 * n));
      load_word((w & keep) | (32'h80 << (24 - 8 * n)));
    end
    if (fill > 14) while (fill != 0) load_word('0);
    while (fill < 14) load_word('0);
    load_word(msg_bits[63:32]);
    load_word(msg_bits[31:0]);
    // digest_high in the lowest bits
    digest_q.push_back({chain[6], chain[7], chain[4], chain[5],
                        chain[2], chain[3], chain[0], chain[1]});
    restart();
  endtask

  always @(posedge clk) begin
    logic [255:0] exp_d;
    if (rst) begin
      restart();
      digest_q.delete();
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) absorb_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          $error("digest with none expected: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_d = digest_q.pop_front();
          if (m_tdata[63:0] !== exp_d[63:0])
            $error("digest_high exp %h got %h", exp_d[63:0], m_tdata[63:0]);
          if (m_tdata[127:64] !== exp_d[127:64])
            $error("digest_upper_mid exp %h got %h", exp_d[127:64], m_tdata[127:64]);
          if (m_tdata[191:128] !== exp_d[191:128])
            $error("digest_lower_mid exp %h got %h", exp_d[191:128], m_tdata[191:128]);
          if (m_tdata[255:192] !== exp_d[255:192])
            $error("digest_low exp %h got %h", exp_d[255:192], m_tdata[255:192]);
          if (m_tdata !== exp_d) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top: drives message words into the sha-256 hasher and gives the verdict
module tb_top;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;    // message_word [31:0], byte_count [34:32]
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [255:0] m_tdata;    // digest_high [63:0] .. digest_low [255:192]
  int           fail_count;
  int           pending_digests;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           words_sent;
  longint       cycle_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  sha256_message_hasher u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sha256_digest_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .pending_digests (pending_digests)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, cnt, w};
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(input int len);
    logic [2:0] cnt;
    for (int i = 0; i < len; i++)
      send_word($urandom, 3'($urandom_range(7)), 1'b0);
    cnt = (len == 0) ? 3'($urandom_range(1) ? 0 : $urandom_range(7))
                     : 3'($urandom_range(7));
    if (len == 0 && cnt == 0) cnt = 0;
    send_word($urandom, cnt, 1'b1);
  endtask

  initial begin
    words_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, full-width extremes and every byte count on the last word
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    for (int c = 1; c <= 5; c++) send_word(32'hffff_ffff, 3'(c), 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    // short non-last word counts as four bytes
    send_word(32'h0, 3'd1, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    // lengths around the extra-block boundary
    send_message(13);
    send_message(14);
    send_message(15);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 36 : 0;
      while (words_sent < 25 + (phase + 1) * 475) begin
        case ($urandom_range(3))
          0: send_message($urandom_range(3));
          1: send_message($urandom_range(12, 17));
          2: send_message($urandom_range(28, 33));
          default: send_message($urandom_range(60));
        endcase
        if ($urandom_range(9) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(20)) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    recv_idle_pct = 0;
    @(posedge clk);

    while (pending_digests != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_digests == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
